// ----- rtl/mrm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrm_pkg - shared definitions for the modem response matcher
// Request kinds, buffer and tail sizes, and the fixed reply strings held
// right-aligned so that the last character sits in the lowest byte.
// ----------------------------------------------------------------------------
package mrm_pkg;

  // sizes
  localparam int BUFFER_BYTES = 99;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int TAIL_LEN     = 10;
  localparam int REPLY_COUNT  = 12;
  localparam int CODE_W       = 4;

  // register indexes on the configuration port
  localparam logic CFG_LINE_TARGET   = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT = 1'b1;

  // configuration reset values
  localparam logic [7:0]  LINE_TARGET_RST   = 8'd1;
  localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd1000;

  // byte codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // request kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef logic [8*TAIL_LEN-1:0] reply_str_t;
  typedef logic [3:0]            reply_len_t;

  // reply strings, right-aligned, zero padded on the left
  localparam reply_str_t REPLY_TAIL [REPLY_COUNT] = '{
    reply_str_t'("OK"),
    reply_str_t'("ERROR"),
    reply_str_t'("CONNECT"),
    reply_str_t'("NO CARRIER"),
    reply_str_t'("IP STATUS"),
    reply_str_t'("IP INITIAL"),
    reply_str_t'("SHUT OK"),
    reply_str_t'("CLOSED"),
    reply_str_t'("DEACT"),
    reply_str_t'("READY"),
    reply_str_t'("."),
    reply_str_t'("POWER DOWN")
  };

  localparam reply_len_t REPLY_LEN [REPLY_COUNT] = '{
    4'd2, 4'd5, 4'd7, 4'd10, 4'd9, 4'd10, 4'd7, 4'd6, 4'd5, 4'd5, 4'd1, 4'd10
  };

  // expected characters of every reply at one tail position
  typedef logic [REPLY_COUNT-1:0][7:0] exp_chars_t;
  typedef logic [REPLY_COUNT-1:0]      reply_vec_t;

  // control from the window logic to one tail cell
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/mrm_tail_cell.sv -----
// ----------------------------------------------------------------------------
// mrm_tail_cell - one character of the tail register
// Holds one stored character, takes its neighbour's character on a shift and
// compares the incoming character against every reply at this position.
// ----------------------------------------------------------------------------
module mrm_tail_cell (
  input  logic                clk,
  input  mrm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          din,
  input  mrm_pkg::exp_chars_t exp_chars,
  input  mrm_pkg::reply_vec_t care,
  output logic [7:0]          dout,
  output mrm_pkg::reply_vec_t eq
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  // clear on a new window, load from the neighbour on a shift
  always_comb begin
    char_nxt = char_r;
    if (ctrl.clr) begin
      char_nxt = mrm_pkg::CHAR_NUL;
    end else if (ctrl.shift) begin
      char_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  // per-reply compare of the character arriving here
  always_comb begin
    for (int r = 0; r < mrm_pkg::REPLY_COUNT; r++) begin
      eq[r] = !care[r] || (din == exp_chars[r]);
    end
  end

  assign dout = char_r;

endmodule

// ----- rtl/modem_response_matcher.sv -----
// ----------------------------------------------------------------------------
// modem_response_matcher - reply string matcher for a modem link
// Result: registered, shows in the cycle after its request is accepted.
// Throughput: one request per cycle while not stalled; the tail compare runs in parallel.
// A request that closes a window waits only while an earlier result is held.
// Reset: synchronous active-low; window idle, line target 1, timeout 1000.
// ----------------------------------------------------------------------------
module modem_response_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_response_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int TL = mrm_pkg::TAIL_LEN;
  localparam int RC = mrm_pkg::REPLY_COUNT;
  localparam int CW = mrm_pkg::CNT_W;

  // configuration registers
  logic [7:0]  line_target_r;
  logic [15:0] timeout_limit_r;

  // window state
  logic                    open_r,  open_nxt;
  logic [RC-1:0]           found_r, found_nxt;
  logic [CW-1:0]           stored_r, stored_nxt;
  logic [7:0]              line_r,  line_nxt;
  logic [15:0]             tick_r,  tick_nxt;
  logic                    zero_r,  zero_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [3:0]              code_r, code_nxt;

  // decode and datapath
  logic                    is_start, is_byte, is_tick, acc;
  logic                    is_eol, store, match_en, emit;
  logic [7:0]              byte_map;
  logic [3:0]              code_c;
  mrm_pkg::cell_ctrl_t     cell_ctrl;
  logic [7:0]              chain [TL+1];
  mrm_pkg::reply_vec_t     cell_eq [TL];
  mrm_pkg::reply_vec_t     match_all;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_target_r   <= mrm_pkg::LINE_TARGET_RST;
      timeout_limit_r <= mrm_pkg::TIMEOUT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrm_pkg::CFG_LINE_TARGET:   line_target_r   <= cfg_wdata[7:0];
        mrm_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request decode
  assign is_start = (in_kind == mrm_pkg::KIND_START);
  assign is_byte  = (in_kind == mrm_pkg::KIND_BYTE) && open_r;
  assign is_tick  = (in_kind == mrm_pkg::KIND_TICK) && open_r;

  // line ends become spaces
  assign is_eol   = (in_rx_byte == mrm_pkg::CHAR_LF) || (in_rx_byte == mrm_pkg::CHAR_CR);
  assign byte_map = is_eol ? mrm_pkg::CHAR_SPACE : in_rx_byte;
  assign store    = is_byte && (stored_r < CW'(mrm_pkg::BUFFER_BYTES));
  assign match_en = store && (byte_map != mrm_pkg::CHAR_NUL) && !zero_r;

  // row of tail cells, newest character enters at the top
  assign chain[TL] = byte_map;
  assign cell_ctrl.clr   = acc && is_start;
  assign cell_ctrl.shift = acc && store;

  for (genvar p = 0; p < TL; p++) begin : g_cell
    mrm_pkg::exp_chars_t exp_p;
    mrm_pkg::reply_vec_t care_p;

    always_comb begin
      for (int r = 0; r < RC; r++) begin
        exp_p[r]  = mrm_pkg::REPLY_TAIL[r][8*(TL-1-p) +: 8];
        care_p[r] = (p >= (TL - int'(mrm_pkg::REPLY_LEN[r])));
      end
    end

    mrm_tail_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .din       (chain[p+1]),
      .exp_chars (exp_p),
      .care      (care_p),
      .dout      (chain[p]),
      .eq        (cell_eq[p])
    );
  end

  // a reply matches when every cell agrees
  always_comb begin
    match_all = '1;
    for (int p = 0; p < TL; p++) begin
      match_all = match_all & cell_eq[p];
    end
  end

  // next window state
  always_comb begin
    found_nxt  = found_r;
    stored_nxt = stored_r;
    line_nxt   = line_r;
    tick_nxt   = tick_r;
    zero_nxt   = zero_r;
    if (store) begin
      stored_nxt = stored_r + CW'(1);
      if (is_eol) begin
        line_nxt = line_r + 8'd1;
      end
      if (byte_map == mrm_pkg::CHAR_NUL) begin
        zero_nxt = 1'b1;
      end
      if (match_en) begin
        found_nxt = found_r | match_all;
      end
    end
    if (is_tick && (tick_r != 16'hFFFF)) begin
      tick_nxt = tick_r + 16'd1;
    end
  end

  // close decision
  always_comb begin
    emit = 1'b0;
    if (is_start) begin
      emit = (timeout_limit_r == 16'd0);
    end else if (is_byte) begin
      emit = (line_nxt == line_target_r);
    end else if (is_tick) begin
      emit = (tick_nxt >= timeout_limit_r);
    end
  end

  // highest-numbered found reply
  always_comb begin
    code_c = 4'd0;
    if (!is_start) begin
      for (int r = 0; r < RC; r++) begin
        if (found_nxt[r]) begin
          code_c = 4'(r + 1);
        end
      end
    end
  end

  // hold back only a request that would overwrite a waiting result
  assign in_stall = out_valid_r && out_stall && emit;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    open_nxt = open_r;
    if (acc) begin
      if (is_start) begin
        open_nxt = (timeout_limit_r != 16'd0);
      end else if (emit) begin
        open_nxt = 1'b0;
      end
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      found_r  <= '0;
      stored_r <= '0;
      line_r   <= '0;
      tick_r   <= '0;
      zero_r   <= 1'b0;
    end else if (acc) begin
      open_r <= open_nxt;
      if (is_start) begin
        found_r  <= '0;
        stored_r <= '0;
        line_r   <= '0;
        tick_r   <= '0;
        zero_r   <= 1'b0;
      end else begin
        found_r  <= found_nxt;
        stored_r <= stored_nxt;
        line_r   <= line_nxt;
        tick_r   <= tick_nxt;
        zero_r   <= zero_nxt;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    if (acc && emit) begin
      out_valid_nxt = 1'b1;
      code_nxt      = code_c;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_response_code = code_r;

endmodule

// ----- test/reply_checker.sv -----
// ----------------------------------------------------------------------------
// reply_checker - reply prediction and comparison for the modem matcher
// Watches the request, reply and register ports, keeps a behavioural copy
// of the reply window and compares every reply with the oldest prediction.
// ----------------------------------------------------------------------------
module reply_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_response_code,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_CHARS  = 10;
  localparam int STORE_LIMIT = 99;
  localparam int N_REPLIES   = 12;

  // reply strings, position plus one is the reply code
  string reply_text [N_REPLIES] = '{"OK", "ERROR", "CONNECT", "NO CARRIER", "IP STATUS",
                                    "IP INITIAL", "SHUT OK", "CLOSED", "DEACT", "READY",
                                    ".", "POWER DOWN"};

  // register copies
  logic [7:0]  line_target;
  logic [15:0] timeout_limit;

  // window state, tail entry TAIL_CHARS-1 is the newest character
  bit                   window_open;
  logic [7:0]           tail [TAIL_CHARS];
  logic [N_REPLIES-1:0] found;
  int                   stored_count;
  logic [7:0]           line_count;
  logic [15:0]          tick_count;
  bit                   zero_seen;

  logic [3:0] expected_replies [$];

  function automatic void clear_window();
    for (int i = 0; i < TAIL_CHARS; i++) tail[i] = 8'h00;
    found        = '0;
    stored_count = 0;
    line_count   = 8'd0;
    tick_count   = 16'd0;
    zero_seen    = 1'b0;
  endfunction

  // compare every reply string with the end of the tail
  function automatic void match_tail();
    int len;
    bit hit;
    for (int r = 0; r < N_REPLIES; r++) begin
      len = reply_text[r].len();
      hit = 1'b1;
      for (int k = 0; k < len; k++)
        if (tail[TAIL_CHARS - len + k] != reply_text[r][k]) hit = 1'b0;
      if (hit) found[r] = 1'b1;
    end
  endfunction

  // highest matched reply wins
  function automatic logic [3:0] close_window();
    logic [3:0] code;
    code = 4'd0;
    for (int r = 0; r < N_REPLIES; r++)
      if (found[r]) code = 4'(r + 1);
    window_open = 1'b0;
    return code;
  endfunction

  // advance the window by one request, returns 1 when a reply is due
  function automatic bit predict_reply(input logic [1:0] kind, input logic [7:0] rx,
                                       output logic [3:0] code);
    logic [7:0] ch;
    code = 4'd0;
    ch   = rx;
    if (kind == mrm_pkg::KIND_START) begin
      clear_window();
      window_open = 1'b1;
      if (timeout_limit == 16'd0) begin
        code = close_window();
        return 1'b1;
      end
      return 1'b0;
    end
    if (!window_open) return 1'b0;
    if (kind == mrm_pkg::KIND_BYTE) begin
      if (stored_count < STORE_LIMIT) begin
        if (ch == mrm_pkg::CHAR_LF || ch == mrm_pkg::CHAR_CR) begin
          ch         = mrm_pkg::CHAR_SPACE;
          line_count = line_count + 8'd1;
        end
        for (int i = 0; i < TAIL_CHARS - 1; i++) tail[i] = tail[i + 1];
        tail[TAIL_CHARS - 1] = ch;
        stored_count++;
        if (ch == mrm_pkg::CHAR_NUL) zero_seen = 1'b1;
        else if (!zero_seen) match_tail();
      end
      if (line_count == line_target) begin
        code = close_window();
        return 1'b1;
      end
    end else if (kind == mrm_pkg::KIND_TICK) begin
      if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
      if (tick_count >= timeout_limit) begin
        code = close_window();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  reply mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // register writes, accepted requests, then accepted replies
  always @(posedge clk) begin : watch_ports
    logic [3:0] code;
    logic [3:0] want;
    if (!rst_n) begin
      line_target   = mrm_pkg::LINE_TARGET_RST;
      timeout_limit = mrm_pkg::TIMEOUT_LIMIT_RST;
      window_open   = 1'b0;
      clear_window();
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mrm_pkg::CFG_LINE_TARGET) line_target = cfg_wdata[7:0];
        else timeout_limit = cfg_wdata;
      end
      if (in_valid && !in_stall)
        if (predict_reply(in_kind, in_rx_byte, code)) expected_replies.push_back(code);
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply code %0d with none expected", out_response_code));
        end else begin
          want = expected_replies.pop_front();
          if (out_response_code !== want)
            report_mismatch($sformatf("response_code %0d, expected %0d",
                                      out_response_code, want));
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench for the modem response matcher
// Directed requests for the corner cases, then random reply windows over a
// series of register settings and idle/stall mixes; a separate checker
// predicts and compares the reply codes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         PHASES         = 8;
  localparam int         PHASE_ITEMS    = 155;

  // register settings per phase, extremes included
  localparam logic [7:0]  PHASE_TARGET  [PHASES] = '{8'd1, 8'd2, 8'd0, 8'd255,
                                                     8'd3, 8'd1, 8'd7, 8'd1};
  localparam logic [15:0] PHASE_TIMEOUT [PHASES] = '{16'd1000, 16'd50, 16'd1, 16'd30,
                                                     16'd65535, 16'd0, 16'd120, 16'd8};

  // texts sent in windows: real replies and near misses
  string reply_words [20] = '{"OK", "ERROR", "CONNECT", "NO CARRIER", "IP STATUS",
                              "IP INITIAL", "SHUT OK", "CLOSED", "DEACT", "READY", ".",
                              "POWER DOWN", "OKAY", "ERRO", "+CME ERROR: 3", "CONNECT OK",
                              "STATE: IP STATUS", "RING", "NO DIALTONE", "AT+CIPSHUT"};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind    = mrm_pkg::KIND_START;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [3:0]  out_response_code;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = mrm_pkg::CFG_LINE_TARGET;
  logic [15:0] cfg_wdata  = 16'h0000;

  int          mismatches;
  int          pending;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          sent_items = 0;
  int          quiet_cycles = 0;
  logic [15:0] cur_timeout = mrm_pkg::TIMEOUT_LIMIT_RST;

  modem_response_matcher i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_response_code (out_response_code),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  reply_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_response_code (out_response_code),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one request, with a random idle gap in front; stall is looked at mid-cycle
  task automatic send_request(input logic [1:0] kind, input logic [7:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= data;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (kind != KIND_UNUSED) sent_items++;
  endtask

  // a received byte, optionally mixed with ticks, restarts and unused kinds
  task automatic send_char(input logic [7:0] ch, input bit mixed);
    int pick;
    pick = $urandom_range(0, 99);
    if (mixed && pick < 8) send_request(mrm_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    else if (mixed && pick < 10) send_request(KIND_UNUSED, 8'($urandom_range(0, 255)));
    else if (mixed && pick < 12) send_request(mrm_pkg::KIND_START, 8'($urandom_range(0, 255)));
    send_request(mrm_pkg::KIND_BYTE, ch);
  endtask

  task automatic send_text(input string s, input bit mixed);
    for (int i = 0; i < s.len(); i++) send_char(s[i], mixed);
  endtask

  // any byte value, zero more often than chance
  function automatic logic [7:0] junk_byte();
    if ($urandom_range(0, 9) == 0) return mrm_pkg::CHAR_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // one reply window: start, lines of text with line ends, trailing ticks
  task automatic send_window();
    int lines;
    int ending;
    send_request(mrm_pkg::KIND_START, 8'($urandom_range(0, 255)));
    // long run to fill the buffer, no line ends inside
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(95, 115)) send_char(8'($urandom_range(8'h21, 8'h7E)), 1'b1);
    lines = $urandom_range(1, 4);
    repeat (lines) begin
      if ($urandom_range(0, 3) != 0) send_text(reply_words[$urandom_range(0, 19)], 1'b1);
      else repeat ($urandom_range(1, 6)) send_char(junk_byte(), 1'b1);
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
        send_char(mrm_pkg::CHAR_CR, 1'b1);
        send_char(mrm_pkg::CHAR_LF, 1'b1);
      end else if (ending == 1) begin
        send_char(mrm_pkg::CHAR_LF, 1'b1);
      end else begin
        send_char(mrm_pkg::CHAR_CR, 1'b1);
      end
    end
    if (cur_timeout <= 16'd120 && $urandom_range(0, 1) == 1)
      repeat (int'(cur_timeout) + 1)
        send_request(mrm_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    else
      repeat ($urandom_range(0, 3))
        send_request(mrm_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // stop sending and wait until every predicted reply is in
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // both registers, junk in the unused upper bits of the line target
  task automatic write_registers(input logic [7:0] target, input logic [15:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= mrm_pkg::CFG_LINE_TARGET;
    cfg_wdata <= {8'($urandom_range(0, 255)), target};
    @(posedge clk);
    cfg_index <= mrm_pkg::CFG_TIMEOUT_LIMIT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_timeout = timeout;
  endtask

  // stimulus
  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // requests while idle are ignored
    send_request(mrm_pkg::KIND_BYTE, 8'hFF);
    send_request(mrm_pkg::KIND_TICK, 8'h00);
    send_request(KIND_UNUSED, 8'hA5);
    // plain reply closed by a carriage return
    send_request(mrm_pkg::KIND_START, 8'h00);
    send_text("OK", 1'b0);
    send_request(mrm_pkg::KIND_BYTE, mrm_pkg::CHAR_CR);
    // zero byte stops matching, so the dot after it is not seen
    send_request(mrm_pkg::KIND_START, 8'hFF);
    send_text("ERROR", 1'b0);
    send_request(mrm_pkg::KIND_BYTE, mrm_pkg::CHAR_NUL);
    send_request(mrm_pkg::KIND_BYTE, 8'h2E);
    send_request(mrm_pkg::KIND_TICK, 8'h5A);
    send_request(mrm_pkg::KIND_BYTE, mrm_pkg::CHAR_LF);
    // restart while open drops the match, then top byte and unused kind
    send_request(mrm_pkg::KIND_START, 8'h00);
    send_text("READY", 1'b0);
    send_request(mrm_pkg::KIND_START, 8'h80);
    send_request(mrm_pkg::KIND_BYTE, 8'h80);
    send_request(KIND_UNUSED, 8'h5A);
    send_request(mrm_pkg::KIND_BYTE, mrm_pkg::CHAR_LF);

    // random windows over register settings and idle/stall mixes
    for (int p = 0; p < PHASES; p++) begin
      wait_drained(4);
      write_registers(PHASE_TARGET[p], PHASE_TIMEOUT[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 77;
        end
        default: begin
          idle_pct = 23;
          stall_pct <= 23;
        end
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) send_window();
    end

    wait_drained(10);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mrm_pkg.sv
rtl/mrm_tail_cell.sv
rtl/modem_response_matcher.sv
test/reply_checker.sv
test/tb_top.sv
